// File: rtl/uer_pkg.sv
package uer_pkg;

  // width of the echo pulse counter, wraps modulo 2**PulseBits
  localparam int PulseBits = 16;

  // widest distance the pulse counter can give, pulse*17/100
  localparam int DistMax = ((2 ** PulseBits - 1) * 17) / 100;
  localparam int DistW   = $clog2(DistMax + 1);
  localparam int CmpW    = (DistW > 14) ? DistW : 14;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 18;

  // sound travels 0.17 tenth-cm per microsecond of round trip
  localparam logic [6:0] DistStep = 7'd17;
  localparam logic [6:0] DistDiv  = 7'd100;

  localparam logic [CfgAddrW-1:0] REG_TRIG_LOW  = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_TRIG_HIGH = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_INTERVAL  = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_TIMEOUT   = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_MIN_DIST  = 3'd4;
  localparam logic [CfgAddrW-1:0] REG_MAX_DIST  = 3'd5;

  localparam logic [17:0] Sat18 = 18'h3FFFF;

  typedef struct packed {
    logic [7:0]  trigger_low_us;
    logic [7:0]  trigger_high_us;
    logic [17:0] interval_us;
    logic [17:0] timeout_us;
    logic [13:0] min_distance;
    logic [13:0] max_distance;
  } cfg_t;

  typedef struct packed {
    logic [13:0] distance_tenth_cm;
    logic [15:0] pulse_us;
    logic        result_valid;
    logic        timed_out;
    logic        done_res;
    logic        busy_res;
    logic        trig_level;
  } res_t;

endpackage

// File: rtl/uer_cfg.sv
module uer_cfg
  import uer_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_low_us  <= 8'd2;
      cfg.trigger_high_us <= 8'd15;
      cfg.interval_us     <= 18'd60000;
      cfg.timeout_us      <= 18'd30000;
      cfg.min_distance    <= 14'd20;
      cfg.max_distance    <= 14'd4000;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TRIG_LOW:  cfg.trigger_low_us  <= cfg_wdata[7:0];
        REG_TRIG_HIGH: cfg.trigger_high_us <= cfg_wdata[7:0];
        REG_INTERVAL:  cfg.interval_us     <= cfg_wdata[17:0];
        REG_TIMEOUT:   cfg.timeout_us      <= cfg_wdata[17:0];
        REG_MIN_DIST:  cfg.min_distance    <= cfg_wdata[13:0];
        REG_MAX_DIST:  cfg.max_distance    <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/uer_core.sv
module uer_core
  import uer_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic accept,
  input  logic command,
  input  logic echo_level,
  output res_t res_next
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TRIG_LOW,
    PH_TRIG_HIGH,
    PH_WAIT_RISE,
    PH_MEASURE
  } phase_t;

  phase_t               phase, phase_next;
  logic [7:0]           phase_count, phase_count_next;
  logic [17:0]          since_start, since_start_next;
  logic [17:0]          wait_count, wait_count_next;
  logic [PulseBits-1:0] echo_width, echo_width_next;
  logic [DistW-1:0]     dist_quo, dist_quo_next;   // running echo_width*17/100
  logic [6:0]           dist_rem, dist_rem_next;   // running remainder mod 100
  logic                 echo_prev, echo_prev_next;
  logic                 done_flag, done_flag_next;
  logic                 timeout_flag, timeout_flag_next;
  logic [PulseBits-1:0] last_pulse, last_pulse_next;
  logic [13:0]          last_distance, last_distance_next;

  logic                 valid;
  logic [17:0]          since_inc, wait_inc;
  logic [7:0]           count_dec, high_load;
  logic [PulseBits-1:0] width_inc;
  logic [7:0]           rem_sum;
  logic [DistW-1:0]     quo_inc;
  logic [6:0]           rem_inc;
  logic [CmpW-1:0]      dist_cmp;

  always_comb begin
    since_inc = (since_start == Sat18) ? Sat18 : since_start + 18'd1;
    wait_inc  = (wait_count == Sat18) ? Sat18 : wait_count + 18'd1;
    count_dec = phase_count - 8'd1;
    high_load = (cfg.trigger_high_us == 8'd0) ? 8'd1 : cfg.trigger_high_us;
    width_inc = echo_width + 1'b1;
    // step the distance by 17/100 per tick, restart when the counter wraps
    rem_sum   = {1'b0, dist_rem} + {1'b0, DistStep};
    if (width_inc == '0) begin
      quo_inc = '0;
      rem_inc = '0;
    end else if (rem_sum >= {1'b0, DistDiv}) begin
      quo_inc = dist_quo + 1'b1;
      rem_inc = 7'(rem_sum - {1'b0, DistDiv});
    end else begin
      quo_inc = dist_quo;
      rem_inc = rem_sum[6:0];
    end
    dist_cmp = CmpW'(quo_inc);
  end

  always_comb begin
    phase_next         = phase;
    phase_count_next   = phase_count;
    since_start_next   = since_start;
    wait_count_next    = wait_count;
    echo_width_next    = echo_width;
    dist_quo_next      = dist_quo;
    dist_rem_next      = dist_rem;
    echo_prev_next     = echo_prev;
    done_flag_next     = done_flag;
    timeout_flag_next  = timeout_flag;
    last_pulse_next    = last_pulse;
    last_distance_next = last_distance;
    valid              = 1'b0;

    if (command) begin
      // clear: not a tick, counters kept
      phase_next         = PH_IDLE;
      done_flag_next     = 1'b0;
      timeout_flag_next  = 1'b0;
      last_distance_next = '0;
    end else begin
      since_start_next = since_inc;
      echo_prev_next   = echo_level;
      if (phase == PH_IDLE) begin
        if (since_inc >= cfg.interval_us) begin
          since_start_next  = '0;
          wait_count_next   = '0;
          last_pulse_next   = '0;
          done_flag_next    = 1'b0;
          timeout_flag_next = 1'b0;
          if (cfg.trigger_low_us == 8'd0) begin
            phase_next       = PH_TRIG_HIGH;
            phase_count_next = high_load;
          end else begin
            phase_next       = PH_TRIG_LOW;
            phase_count_next = cfg.trigger_low_us;
          end
        end
      end else begin
        wait_count_next = wait_inc;
        if (wait_inc > cfg.timeout_us) begin
          phase_next         = PH_IDLE;
          timeout_flag_next  = 1'b1;
          done_flag_next     = 1'b1;
          last_distance_next = '0;
          valid              = 1'b1;
        end else begin
          unique case (phase)
            PH_TRIG_LOW: begin
              phase_count_next = count_dec;
              if (count_dec == 8'd0) begin
                phase_next       = PH_TRIG_HIGH;
                phase_count_next = high_load;
              end
            end
            PH_TRIG_HIGH: begin
              phase_count_next = count_dec;
              if (count_dec == 8'd0) begin
                phase_next = PH_WAIT_RISE;
              end
            end
            PH_WAIT_RISE: begin
              if (echo_level && !echo_prev) begin
                phase_next      = PH_MEASURE;
                echo_width_next = '0;
                dist_quo_next   = '0;
                dist_rem_next   = '0;
              end
            end
            default: begin
              echo_width_next = width_inc;
              dist_quo_next   = quo_inc;
              dist_rem_next   = rem_inc;
              if (!echo_level) begin
                last_pulse_next = width_inc;
                if (dist_cmp < CmpW'(cfg.min_distance) ||
                    dist_cmp > CmpW'(cfg.max_distance)) begin
                  last_distance_next = '0;
                end else begin
                  last_distance_next = 14'(quo_inc);
                end
                done_flag_next    = 1'b1;
                timeout_flag_next = 1'b0;
                phase_next        = PH_IDLE;
                valid             = 1'b1;
              end
            end
          endcase
        end
      end
    end

    res_next.trig_level        = (phase_next == PH_TRIG_HIGH);
    res_next.busy_res          = (phase_next != PH_IDLE);
    res_next.done_res          = done_flag_next;
    res_next.timed_out         = timeout_flag_next;
    res_next.result_valid      = valid;
    res_next.pulse_us          = 16'(last_pulse_next);
    res_next.distance_tenth_cm = last_distance_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      phase_count   <= '0;
      since_start   <= '0;
      wait_count    <= '0;
      echo_width    <= '0;
      dist_quo      <= '0;
      dist_rem      <= '0;
      echo_prev     <= 1'b0;
      done_flag     <= 1'b0;
      timeout_flag  <= 1'b0;
      last_pulse    <= '0;
      last_distance <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      phase_count   <= phase_count_next;
      since_start   <= since_start_next;
      wait_count    <= wait_count_next;
      echo_width    <= echo_width_next;
      dist_quo      <= dist_quo_next;
      dist_rem      <= dist_rem_next;
      echo_prev     <= echo_prev_next;
      done_flag     <= done_flag_next;
      timeout_flag  <= timeout_flag_next;
      last_pulse    <= last_pulse_next;
      last_distance <= last_distance_next;
    end
  end

endmodule

// File: rtl/ultrasonic_echo_ranger_top.sv
// Ultrasonic ranging controller. Each input item is one microsecond tick carrying
// the sampled echo level (s_tuser = 0), or a clear command (s_tuser = 1). Every item
// gives exactly one result item: trigger pin level, busy/done/timeout status, a
// one-item result_valid strobe, the last echo width in us and the distance in
// tenths of a cm (width*17/100, 0 when outside the min/max window or on
// timeout). The distance is kept as a running quotient and remainder that step
// by 17 each echo tick, so no divider sits in the path. One item is taken per
// clock while the result stream is not stalled: the state update is a single
// pass of logic and the result sits in one output register, which reloads in
// the same cycle it is taken. Registers are written through
// cfg_we/cfg_addr/cfg_wdata and should only change while no measurement is running.
module ultrasonic_echo_ranger_top
  import uer_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // input item stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [0] echo_level, [7:1] zero
  input  logic                s_tuser,   // [0] command (0 tick, 1 clear)
  // result item stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [39:0]         m_tdata,   // [0] trig_level, [1] busy_res, [2] done_res,
                                         // [3] timed_out, [4] result_valid,
                                         // [20:5] pulse_us, [34:21] distance_tenth_cm,
                                         // [39:35] zero
  // register write port
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t cfg;
  res_t res_next;
  res_t res;
  logic accept;

  // output register frees up in the same cycle it is drained
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  uer_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  uer_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .command    (s_tuser),
    .echo_level (s_tdata[0]),
    .res_next   (res_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign m_tdata = {5'd0, res.distance_tenth_cm, res.pulse_us, res.result_valid,
                    res.timed_out, res.done_res, res.busy_res, res.trig_level};

endmodule
